/* rtl/core/wer_pkg.sv */
`timescale 1ns / 1ps
package wer_pkg;

  // fraction bits of the log2 result
  localparam int LOG_FRAC = 24;

  typedef struct packed {
    logic signed [15:0] range_low;
    logic signed [15:0] range_high;
    logic [6:0]         window_length;
    logic [6:0]         bucket_count;
    logic [15:0]        spike_level;
    logic [15:0]        hold_ticks;
  } wer_cfg_t;

endpackage

/* rtl/core/wer_if.sv */
`timescale 1ns / 1ps
interface wer_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wer_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] entropy;
  logic [15:0] floor_level;
  logic        spike_flag;
  logic        spike_started;
  logic        floor_dropped;
  logic [31:0] spike_count;
  logic [31:0] drop_count;
  logic [31:0] sample_count;

  modport source (output valid, output entropy, output floor_level, output spike_flag,
                  output spike_started, output floor_dropped, output spike_count,
                  output drop_count, output sample_count, input ready);
  modport sink (input valid, input entropy, input floor_level, input spike_flag,
                input spike_started, input floor_dropped, input spike_count,
                input drop_count, input sample_count, output ready);
endinterface

/* rtl/core/windowed_entropy_ratchet.sv */
`timescale 1ns / 1ps
// front end: takes no new sample until the previous bucket index is pushed to the queue
// back end: takes one bucket index at a time, its time per item set by the 24-step log2 squaring loop and the
//   (window bits + log bits - 11)-step entropy divide; this sets the sustained rate
// reset: synchronous active low, registers to defaults, histogram valid bits cleared at once
// a write to window_length or bucket_count clears window, histogram and floor state
module windowed_entropy_ratchet import wer_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int BUCKETS_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  wer_in_if.sink      in_ch,
  wer_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = $clog2(BUCKETS_MAX);

  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
  localparam logic [2:0] REG_WINDOW_LEN = 3'd2;
  localparam logic [2:0] REG_BUCKET_CNT = 3'd3;
  localparam logic [2:0] REG_SPIKE_THR  = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS = 3'd5;

  wer_cfg_t      cfg_r;
  logic          wr;
  logic [2:0]    idx;
  logic          clr;
  logic          q_push;
  logic [IW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic [IW-1:0] q_pop_data;
  logic          q_empty;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx = cfg_paddr[4:2];
  assign clr = wr && (idx == REG_WINDOW_LEN || idx == REG_BUCKET_CNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_low     <= 16'sh8000;
      cfg_r.range_high    <= 16'sh7FFF;
      cfg_r.window_length <= 7'd32;
      cfg_r.bucket_count  <= 7'd16;
      cfg_r.spike_level   <= 16'd16384;
      cfg_r.hold_ticks    <= 16'd1;
    end else if (wr) begin
      case (idx)
        REG_RANGE_LOW:  cfg_r.range_low     <= cfg_pwdata[15:0];
        REG_RANGE_HIGH: cfg_r.range_high    <= cfg_pwdata[15:0];
        REG_WINDOW_LEN: cfg_r.window_length <= cfg_pwdata[6:0];
        REG_BUCKET_CNT: cfg_r.bucket_count  <= cfg_pwdata[6:0];
        REG_SPIKE_THR:  cfg_r.spike_level   <= cfg_pwdata[15:0];
        REG_HOLD_TICKS: cfg_r.hold_ticks    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RANGE_LOW:  cfg_prdata = 32'(unsigned'(cfg_r.range_low));
      REG_RANGE_HIGH: cfg_prdata = 32'(unsigned'(cfg_r.range_high));
      REG_WINDOW_LEN: cfg_prdata = 32'(cfg_r.window_length);
      REG_BUCKET_CNT: cfg_prdata = 32'(cfg_r.bucket_count);
      REG_SPIKE_THR:  cfg_prdata = 32'(cfg_r.spike_level);
      REG_HOLD_TICKS: cfg_prdata = 32'(cfg_r.hold_ticks);
      default:        cfg_prdata = '0;
    endcase
  end

  wer_front #(.BUCKETS_MAX(BUCKETS_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  wer_queue #(.WIDTH(IW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  wer_back #(.WINDOW_MAX(WINDOW_MAX), .BUCKETS_MAX(BUCKETS_MAX)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .clr      (clr),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty),
    .out_ch   (out_ch)
  );

endmodule

/* rtl/core/wer_ram.sv */
`timescale 1ns / 1ps
module wer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/wer_div.sv */
`timescale 1ns / 1ps
module wer_div #(
  parameter int NW = 23,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   acc_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     sh;
  logic            ge;

  // restoring step, one quotient bit a cycle
  assign sh = {rem_r, acc_r[NW-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      acc_r <= {acc_r[NW-2:0], ge};
      rem_r <= ge ? DW'(sh - {1'b0, den_r}) : DW'(sh);
    end
  end

  assign done = done_r;
  assign quo  = acc_r;

endmodule

/* rtl/core/wer_log2.sv */
`timescale 1ns / 1ps
module wer_log2 import wer_pkg::*; #(
  parameter int XW = 7
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [XW-1:0]                                 x,
  output logic                                          done,
  output logic [LOG_FRAC+((XW > 1) ? $clog2(XW) : 1)-1:0] res
);

  localparam int KW = (XW > 1) ? $clog2(XW) : 1;

  logic [KW-1:0]       k;
  logic [KW-1:0]       k_r;
  logic [31:0]         y_r;
  logic [LOG_FRAC-1:0] frac_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [63:0]         sq;
  logic [32:0]         t;

  // integer part: position of the leading one
  always_comb begin
    k = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        k = KW'(i);
      end
    end
  end

  assign sq = 64'(y_r) * 64'(y_r);
  assign t  = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(LOG_FRAC);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r    <= k;
      y_r    <= 32'(x) << (5'd31 - 5'(k));
      frac_r <= '0;
    end else if (busy_r) begin
      frac_r <= {frac_r[LOG_FRAC-2:0], t[32]};
      y_r    <= t[32] ? t[32:1] : t[31:0];
    end
  end

  assign done = done_r;
  assign res  = {k_r, frac_r};

endmodule

/* rtl/core/wer_queue.sv */
`timescale 1ns / 1ps
module wer_queue #(
  parameter int WIDTH = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_r;
  logic             rd_r;
  logic [1:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_r];
  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;

endmodule

/* rtl/core/wer_front.sv */
`timescale 1ns / 1ps
module wer_front import wer_pkg::*; #(
  parameter int BUCKETS_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wer_cfg_t                       cfg,
  wer_in_if.sink                         in_ch,
  output logic                           push,
  output logic [$clog2(BUCKETS_MAX)-1:0] push_data,
  input  logic                           q_full
);

  localparam int BW = $clog2(BUCKETS_MAX + 1);
  localparam int IW = $clog2(BUCKETS_MAX);
  localparam int NW = 16 + BW;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_CALC = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fst_t;

  fst_t               st_r;
  logic signed [15:0] smp_r;
  logic [IW-1:0]      bkt_r;
  logic [BW-1:0]      nb;
  logic signed [16:0] dif;
  logic signed [16:0] rng;
  logic               zero_case;
  logic [NW-1:0]      prod;
  logic               div_done;
  logic [NW-1:0]      quo;
  logic [IW-1:0]      qb;

  always_comb begin
    if (cfg.bucket_count < 7'd2) begin
      nb = BW'(2);
    end else if (32'(cfg.bucket_count) > 32'(BUCKETS_MAX)) begin
      nb = BW'(BUCKETS_MAX);
    end else begin
      nb = BW'(cfg.bucket_count);
    end
  end

  assign dif = $signed({smp_r[15], smp_r}) - $signed({cfg.range_low[15], cfg.range_low});
  assign rng = $signed({cfg.range_high[15], cfg.range_high}) -
               $signed({cfg.range_low[15], cfg.range_low});
  assign zero_case = (rng <= 17'sd0) || (dif <= 17'sd0);
  assign prod = NW'(dif[15:0]) * NW'(nb);
  assign qb   = (quo >= NW'(nb)) ? IW'(nb - 1'b1) : IW'(quo);

  wer_div #(.NW(NW), .DW(16)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == F_CALC && !zero_case),
    .num   (prod),
    .den   (rng[15:0]),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            st_r <= F_CALC;
          end
        end
        F_CALC: begin
          st_r <= zero_case ? F_PUSH : F_DIV;
        end
        F_DIV: begin
          if (div_done) begin
            st_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_ch.valid) begin
      smp_r <= in_ch.sample;
    end
    if (st_r == F_CALC && zero_case) begin
      bkt_r <= '0;
    end else if (st_r == F_DIV && div_done) begin
      bkt_r <= qb;
    end
  end

  assign in_ch.ready = st_r == F_IDLE;
  assign push        = st_r == F_PUSH && !q_full;
  assign push_data   = bkt_r;

endmodule

/* rtl/core/wer_back.sv */
`timescale 1ns / 1ps
module wer_back import wer_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int BUCKETS_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wer_cfg_t                       cfg,
  input  logic                           clr,
  output logic                           pop,
  input  logic [$clog2(BUCKETS_MAX)-1:0] pop_data,
  input  logic                           empty,
  wer_out_if.source                      out_ch
);

  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int HW  = $clog2(WINDOW_MAX);
  localparam int IW  = $clog2(BUCKETS_MAX);
  localparam int LKW = (CW > 1) ? $clog2(CW) : 1;
  localparam int LW  = LOG_FRAC + LKW;
  localparam int TW  = CW + LW;
  localparam int NQ  = TW - 11;
  localparam int HEW = CW + TW;

  typedef enum logic [10:0] {
    B_IDLE = 11'b00000000001,
    B_RDO  = 11'b00000000010,
    B_LOG  = 11'b00000000100,
    B_WAIT = 11'b00000001000,
    B_TERM = 11'b00000010000,
    B_SUM  = 11'b00000100000,
    B_WRO  = 11'b00001000000,
    B_T    = 11'b00010000000,
    B_DST  = 11'b00100000000,
    B_DIV  = 11'b01000000000,
    B_FIN  = 11'b10000000000
  } bst_t;

  bst_t            st_r;
  logic [HW-1:0]   hp_r;
  logic [CW-1:0]   fill_r;
  logic [TW-1:0]   s_sum_r;
  logic            hvalid_r [BUCKETS_MAX];
  logic            hv_q_r;
  logic [15:0]     floor_r;
  logic            seeded_r;
  logic [15:0]     streak_r;
  logic            prev_r;
  logic [31:0]     spike_tot_r;
  logic [31:0]     drop_tot_r;
  logic [31:0]     rec_tot_r;

  logic [IW-1:0]   b_r;
  logic [IW-1:0]   o_r;
  logic [HW-1:0]   hp_use_r;
  logic            full_r;
  logic [CW-1:0]   cnt_b_r;
  logic [TW-1:0]   term_b_r;
  logic [TW-1:0]   term_o_r;
  logic            dec_r;
  logic            same_r;
  logic [CW-1:0]   co_r;
  logic [CW-1:0]   cn_r;
  logic [CW-1:0]   n_r;
  logic [TW-1:0]   to_r;
  logic [TW-1:0]   tn_r;
  logic [TW-1:0]   tt_r;
  logic [TW-1:0]   t_r;

  logic            out_valid_r;
  logic [15:0]     ent_out_r;
  logic [15:0]     floor_out_r;
  logic            spiked_out_r;
  logic            started_out_r;
  logic            dropped_out_r;

  logic [CW-1:0]   w_use;
  logic [HW-1:0]   hp_use;
  logic            hre;
  logic [IW-1:0]   hraddr;
  logic            hwe;
  logic [IW-1:0]   hwaddr;
  logic [HEW-1:0]  hwdata;
  logic [HEW-1:0]  hrdata;
  logic [IW-1:0]   win_rdata;
  logic [CW-1:0]   rd_cnt;
  logic [TW-1:0]   rd_term;
  logic            dec;
  logic            same;
  logic [CW-1:0]   co;
  logic [CW-1:0]   cn;
  logic [CW-1:0]   n_new;
  logic [CW-1:0]   hp_inc;
  logic            log_go;
  logic            lo_done;
  logic            ln_done;
  logic            lt_done;
  logic [LW-1:0]   lo_res;
  logic [LW-1:0]   ln_res;
  logic [LW-1:0]   lt_res;
  logic [TW:0]     nsum;
  logic            div_done;
  logic [NQ-1:0]   quo;
  logic            out_free;
  logic            fin;
  logic [15:0]     h;
  logic            spiked;
  logic            started;
  logic [15:0]     streak_inc;
  logic [15:0]     hold;
  logic            drop_now;
  logic [15:0]     floor_nxt;
  logic [15:0]     streak_nxt;

  always_comb begin
    if (cfg.window_length < 7'd2) begin
      w_use = CW'(2);
    end else if (32'(cfg.window_length) > 32'(WINDOW_MAX)) begin
      w_use = CW'(WINDOW_MAX);
    end else begin
      w_use = CW'(cfg.window_length);
    end
  end

  assign hp_use = (CW'(hp_r) >= w_use) ? '0 : hp_r;

  // bucket b is read while idle, the evicted bucket in the following cycle
  assign hre    = (st_r == B_IDLE && !empty) || st_r == B_RDO;
  assign hraddr = (st_r == B_RDO) ? win_rdata : pop_data;
  assign hwe    = st_r == B_SUM || st_r == B_WRO;
  assign hwaddr = (st_r == B_WRO) ? o_r : b_r;
  assign hwdata = (st_r == B_WRO) ? {co_r, to_r} : {cn_r, tn_r};
  assign rd_cnt  = hv_q_r ? hrdata[HEW-1:TW] : '0;
  assign rd_term = hv_q_r ? hrdata[TW-1:0] : '0;

  wer_ram #(.WIDTH(HEW), .DEPTH(BUCKETS_MAX)) u_hist (
    .clk   (clk),
    .we    (hwe),
    .waddr (hwaddr),
    .wdata (hwdata),
    .re    (hre),
    .raddr (hraddr),
    .rdata (hrdata)
  );

  wer_ram #(.WIDTH(IW), .DEPTH(WINDOW_MAX)) u_win (
    .clk   (clk),
    .we    (st_r == B_LOG),
    .waddr (hp_use_r),
    .wdata (b_r),
    .re    (st_r == B_IDLE && !empty),
    .raddr (hp_use),
    .rdata (win_rdata)
  );

  assign dec    = full_r && rd_cnt != '0;
  assign same   = dec && (o_r == b_r);
  assign co     = rd_cnt - 1'b1;
  assign cn     = same ? cnt_b_r : cnt_b_r + 1'b1;
  assign n_new  = full_r ? w_use : fill_r + 1'b1;
  assign hp_inc = CW'(hp_use_r) + 1'b1;
  assign log_go = st_r == B_LOG;

  wer_log2 #(.XW(CW)) u_log_o (
    .clk(clk), .rst_n(rst_n), .start(log_go), .x(co), .done(lo_done), .res(lo_res)
  );

  wer_log2 #(.XW(CW)) u_log_n (
    .clk(clk), .rst_n(rst_n), .start(log_go), .x(cn), .done(ln_done), .res(ln_res)
  );

  wer_log2 #(.XW(CW)) u_log_t (
    .clk(clk), .rst_n(rst_n), .start(log_go), .x(n_new), .done(lt_done), .res(lt_res)
  );

  // rounding: (t + n*2^11) / (n*2^12), the 2^12 taken out as a shift
  assign nsum = {1'b0, t_r} + (TW + 1)'({n_r, 11'b0});

  wer_div #(.NW(NQ), .DW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == B_DST),
    .num   (nsum[TW:12]),
    .den   (n_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign fin      = st_r == B_FIN && out_free;
  assign h        = (quo > NQ'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
  assign spiked   = h > cfg.spike_level;
  assign started  = spiked && !prev_r;
  assign streak_inc = (streak_r == 16'hFFFF) ? streak_r : streak_r + 1'b1;
  assign hold       = (cfg.hold_ticks == 16'd0) ? 16'd1 : cfg.hold_ticks;

  // ratchet floor: seed, rise at once, fall after the hold streak
  always_comb begin
    drop_now   = 1'b0;
    floor_nxt  = floor_r;
    streak_nxt = streak_r;
    if (!seeded_r) begin
      floor_nxt = h;
    end else if (h > floor_r) begin
      floor_nxt  = h;
      streak_nxt = '0;
    end else begin
      streak_nxt = streak_inc;
      if (streak_inc >= hold && h < floor_r) begin
        floor_nxt  = h;
        drop_now   = 1'b1;
        streak_nxt = '0;
      end
    end
  end

  assign pop = st_r == B_IDLE && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      hp_r        <= '0;
      fill_r      <= '0;
      s_sum_r     <= '0;
      hv_q_r      <= 1'b0;
      floor_r     <= '0;
      seeded_r    <= 1'b0;
      streak_r    <= '0;
      prev_r      <= 1'b0;
      spike_tot_r <= '0;
      drop_tot_r  <= '0;
      rec_tot_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BUCKETS_MAX; i++) begin
        hvalid_r[i] <= 1'b0;
      end
    end else if (clr) begin
      hp_r     <= '0;
      fill_r   <= '0;
      s_sum_r  <= '0;
      floor_r  <= '0;
      seeded_r <= 1'b0;
      streak_r <= '0;
      prev_r   <= 1'b0;
      for (int i = 0; i < BUCKETS_MAX; i++) begin
        hvalid_r[i] <= 1'b0;
      end
    end else begin
      if (hre) begin
        hv_q_r <= hvalid_r[hraddr];
      end
      if (hwe) begin
        hvalid_r[hwaddr] <= 1'b1;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        B_IDLE: begin
          if (!empty) begin
            st_r <= B_RDO;
          end
        end
        B_RDO: st_r <= B_LOG;
        B_LOG: begin
          hp_r   <= (hp_inc == w_use) ? '0 : HW'(hp_inc);
          fill_r <= n_new;
          st_r   <= B_WAIT;
        end
        B_WAIT: begin
          if (lt_done) begin
            st_r <= B_TERM;
          end
        end
        B_TERM: st_r <= B_SUM;
        B_SUM: begin
          s_sum_r <= s_sum_r - term_b_r + tn_r +
                     ((dec_r && !same_r) ? to_r - term_o_r : '0);
          st_r    <= (dec_r && !same_r) ? B_WRO : B_T;
        end
        B_WRO: st_r <= B_T;
        B_T:   st_r <= B_DST;
        B_DST: st_r <= B_DIV;
        B_DIV: begin
          if (div_done) begin
            st_r <= B_FIN;
          end
        end
        B_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            floor_r     <= floor_nxt;
            seeded_r    <= 1'b1;
            streak_r    <= streak_nxt;
            prev_r      <= spiked;
            spike_tot_r <= spike_tot_r + 32'(started);
            drop_tot_r  <= drop_tot_r + 32'(drop_now);
            rec_tot_r   <= rec_tot_r + 1'b1;
            st_r        <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_r      <= pop_data;
      hp_use_r <= hp_use;
      full_r   <= fill_r >= w_use;
    end
    if (st_r == B_RDO) begin
      o_r      <= win_rdata;
      cnt_b_r  <= rd_cnt;
      term_b_r <= rd_term;
    end
    if (st_r == B_LOG) begin
      term_o_r <= rd_term;
      dec_r    <= dec;
      same_r   <= same;
      co_r     <= co;
      cn_r     <= cn;
      n_r      <= n_new;
    end
    if (st_r == B_TERM) begin
      to_r <= TW'(co_r) * TW'(lo_res);
      tn_r <= TW'(cn_r) * TW'(ln_res);
      tt_r <= TW'(n_r) * TW'(lt_res);
    end
    if (st_r == B_T) begin
      t_r <= (tt_r > s_sum_r) ? tt_r - s_sum_r : '0;
    end
    if (fin) begin
      ent_out_r     <= h;
      floor_out_r   <= floor_nxt;
      spiked_out_r  <= spiked;
      started_out_r <= started;
      dropped_out_r <= drop_now;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.entropy       = ent_out_r;
  assign out_ch.floor_level   = floor_out_r;
  assign out_ch.spike_flag    = spiked_out_r;
  assign out_ch.spike_started = started_out_r;
  assign out_ch.floor_dropped = dropped_out_r;
  assign out_ch.spike_count   = spike_tot_r;
  assign out_ch.drop_count    = drop_tot_r;
  assign out_ch.sample_count  = rec_tot_r;

`ifndef NO_ASSERTIONS
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_FIN && out_free && !clr) |=> out_valid_r)
    else $error("result not loaded after finish");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DST) |-> (n_r != '0))
    else $error("entropy divide by zero count");

  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_WAIT) |-> (fill_r <= w_use && CW'(hp_r) < w_use))
    else $error("window pointer or fill out of range");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [15:0] entropy;
    logic [15:0] floor_level;
    logic        spike_flag;
    logic        spike_started;
    logic        floor_dropped;
    logic [31:0] spike_count;
    logic [31:0] drop_count;
    logic [31:0] sample_count;
  } ratchet_beat_t;

  typedef enum int {GEN_ANY, GEN_CLUSTER, GEN_RUNS} sample_mix_e;

  localparam int REG_LOW = 0, REG_HIGH = 1, REG_WINDOW = 2, REG_BUCKETS = 3,
                 REG_THRESH = 4, REG_HOLD = 5, REG_SPARE6 = 6, REG_SPARE7 = 7;
  localparam int DRAIN_CYCLES = 150;

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  wer_in_if  in_if ();
  wer_out_if out_if ();

  windowed_entropy_ratchet i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor state
  logic signed [15:0] p_low, p_high;
  logic [6:0]         p_window, p_buckets;
  logic [15:0]        p_thresh, p_hold;
  logic [5:0]         p_slots [64];
  int unsigned        p_hist [64];
  int unsigned        p_head, p_fill, p_streak;
  logic [15:0]        p_floor;
  logic               p_seeded, p_prev_spike;
  logic [31:0]        p_spikes, p_drops, p_records;

  logic signed [15:0] samples_pending [$];
  ratchet_beat_t      results_due [$];
  int                 mismatches = 0;
  logic               in_beat = 1'b0;
  int                 send_gap = 0, recv_stall = 0;
  logic               idling_on = 1'b1;

  logic signed [15:0] corner_samples [10] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
                                             16'sh0001, 16'sh8001, 16'sh7FFE, 16'sh5555,
                                             16'shAAAA, 16'sh0000};
  logic signed [15:0] ratchet_samples [6] = '{16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                             16'sh8000, 16'sh8000};

  function automatic int unsigned clamp_range(int unsigned v);
    return v < 2 ? 2 : (v > 64 ? 64 : v);
  endfunction

  function automatic longint unsigned log2_q24(int unsigned x);
    int unsigned k = 0;
    longint unsigned y, r;
    if (x == 0) return 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    y = longint'(x) << (31 - k);
    r = longint'(k) << 24;
    for (int i = 23; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        r[i] = 1'b1;
        y = y >> 1;
      end
    end
    return r;
  endfunction

  function automatic int unsigned bucket_of(logic signed [15:0] s, int unsigned nb);
    int lo = p_low;
    int span = int'(p_high) - lo;
    int d = int'(s) - lo;
    longint b;
    if (span <= 0 || d <= 0) return 0;
    b = (longint'(d) * longint'(nb)) / longint'(span);
    if (b >= nb) b = nb - 1;
    return int'(b);
  endfunction

  function automatic logic [15:0] window_entropy();
    longint unsigned n = p_fill;
    longint unsigned s = 0, t, e;
    if (n == 0) return 0;
    for (int i = 0; i < 64; i++)
      if (p_hist[i] != 0) s += longint'(p_hist[i]) * log2_q24(p_hist[i]);
    t = n * log2_q24(p_fill);
    t = (t > s) ? t - s : 0;
    e = (t + n * 2048) / (n * 4096);
    return e > 65535 ? 16'hFFFF : e[15:0];
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 64; i++) begin
      p_slots[i] = '0;
      p_hist[i] = 0;
    end
    p_head = 0;
    p_fill = 0;
    p_floor = '0;
    p_seeded = 1'b0;
    p_streak = 0;
    p_prev_spike = 1'b0;
  endfunction

  function automatic void apply_register(int idx, logic [31:0] val);
    case (idx)
      REG_LOW: p_low = val[15:0];
      REG_HIGH: p_high = val[15:0];
      REG_WINDOW: begin
        p_window = val[6:0];
        clear_window();
      end
      REG_BUCKETS: begin
        p_buckets = val[6:0];
        clear_window();
      end
      REG_THRESH: p_thresh = val[15:0];
      REG_HOLD: p_hold = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_entropy(logic signed [15:0] s);
    int unsigned w = clamp_range(p_window);
    int unsigned nb = clamp_range(p_buckets);
    int unsigned bkt = bucket_of(s, nb);
    int unsigned hold;
    ratchet_beat_t r;
    logic [15:0] h;
    r = '0;
    p_records++;
    if (p_head >= w) p_head = 0;
    if (p_fill >= w) begin
      if (p_hist[p_slots[p_head]] > 0) p_hist[p_slots[p_head]]--;
      p_fill = w;
    end else begin
      p_fill++;
    end
    p_slots[p_head] = bkt[5:0];
    p_head = (p_head + 1) % w;
    p_hist[bkt]++;
    h = window_entropy();
    r.spike_flag = h > p_thresh;
    if (r.spike_flag && !p_prev_spike) begin
      r.spike_started = 1'b1;
      p_spikes++;
    end
    p_prev_spike = r.spike_flag;
    if (!p_seeded) begin
      p_floor = h;
      p_seeded = 1'b1;
    end else if (h > p_floor) begin
      p_floor = h;
      p_streak = 0;
    end else begin
      if (p_streak < 65535) p_streak++;
      hold = p_hold == 0 ? 1 : p_hold;
      if (p_streak >= hold && h < p_floor) begin
        p_floor = h;
        p_drops++;
        r.floor_dropped = 1'b1;
        p_streak = 0;
      end
    end
    r.entropy = h;
    r.floor_level = p_floor;
    r.spike_count = p_spikes;
    r.drop_count = p_drops;
    r.sample_count = p_records;
    results_due.push_back(r);
  endfunction

  // sender
  always @(posedge clk) begin
    in_beat = rst_n && in_if.valid && in_if.ready;
    if (in_beat) predict_entropy(in_if.sample);
  end

  always @(negedge clk) begin
    if (in_beat || !in_if.valid) begin
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (samples_pending.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.sample <= samples_pending.pop_front();
        if (idling_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (idling_on && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    ratchet_beat_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.entropy, out_if.floor_level, out_if.spike_flag, out_if.spike_started,
              out_if.floor_dropped, out_if.spike_count, out_if.drop_count,
              out_if.sample_count};
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = results_due.pop_front();
        if (got.entropy !== want.entropy || got.floor_level !== want.floor_level ||
            got.spike_flag !== want.spike_flag || got.spike_started !== want.spike_started ||
            got.floor_dropped !== want.floor_dropped ||
            got.spike_count !== want.spike_count || got.drop_count !== want.drop_count ||
            got.sample_count !== want.sample_count) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic wait_idle();
    while (samples_pending.size() > 0 || in_if.valid || results_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(int idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx * 4);
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    apply_register(idx, val);
  endtask

  task automatic queue_samples(int count, sample_mix_e mix);
    int center = $urandom_range(0, 65535) - 32768;
    int spread = 1 << $urandom_range(0, 15);
    int run = 0;
    logic signed [15:0] held = '0;
    for (int i = 0; i < count; i++) begin
      case (mix)
        GEN_ANY: samples_pending.push_back(16'($urandom_range(0, 65535)));
        GEN_CLUSTER: begin
          if ($urandom_range(0, 19) == 0) begin
            center = $urandom_range(0, 65535) - 32768;
            spread = 1 << $urandom_range(0, 15);
          end
          samples_pending.push_back(16'(center + $urandom_range(0, spread) - spread / 2));
        end
        default: begin
          if (run == 0) begin
            run = $urandom_range(1, 40);
            held = 16'($urandom_range(0, 65535));
          end
          run--;
          samples_pending.push_back($urandom_range(0, 7) == 0 ? 16'($urandom) : held);
        end
      endcase
    end
  endtask

  task automatic random_phase(int count);
    write_register(REG_LOW, $urandom_range(0, 65535));
    write_register(REG_HIGH, $urandom_range(0, 65535));
    write_register(REG_WINDOW, $urandom_range(2, 64));
    write_register(REG_BUCKETS, $urandom_range(2, 64));
    write_register(REG_THRESH, $urandom_range(0, 20000));
    write_register(REG_HOLD, $urandom_range(0, 6));
    queue_samples(count / 3, GEN_ANY);
    queue_samples(count / 3, GEN_CLUSTER);
    queue_samples(count - 2 * (count / 3), GEN_RUNS);
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    p_low = -16'sd32768;
    p_high = 16'sd32767;
    p_window = 7'd32;
    p_buckets = 7'd16;
    p_thresh = 16'd16384;
    p_hold = 16'd1;
    p_spikes = '0;
    p_drops = '0;
    p_records = '0;
    clear_window();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, seeding, equal-to-floor, drop after hold
    foreach (corner_samples[i])
      samples_pending.push_back(corner_samples[i]);
    wait_idle();
    write_register(REG_WINDOW, 2);
    write_register(REG_HOLD, 0);
    write_register(REG_THRESH, 0);
    foreach (ratchet_samples[i])
      samples_pending.push_back(ratchet_samples[i]);
    wait_idle();
    // empty range puts everything in bucket zero; reversed range too
    write_register(REG_LOW, 16'h0064);
    write_register(REG_HIGH, 16'h0064);
    samples_pending.push_back(16'sh8000);
    samples_pending.push_back(16'sh7FFF);
    wait_idle();
    write_register(REG_HIGH, 16'hFF9C);
    write_register(REG_HOLD, 16'hFFFF);
    write_register(REG_THRESH, 16'hFFFF);
    samples_pending.push_back(16'sh7FFF);
    samples_pending.push_back(16'sh0000);
    wait_idle();
    // out-of-range window and bucket counts are clamped; spare addresses ignored
    write_register(REG_LOW, 16'hFC18);
    write_register(REG_HIGH, 16'h03E8);
    write_register(REG_WINDOW, 0);
    write_register(REG_BUCKETS, 127);
    write_register(REG_SPARE6, 32'hFFFF_FFFF);
    write_register(REG_SPARE7, 32'h0000_0003);
    queue_samples(30, GEN_CLUSTER);
    wait_idle();
    write_register(REG_WINDOW, 127);
    write_register(REG_BUCKETS, 1);
    queue_samples(30, GEN_RUNS);
    wait_idle();
    write_register(REG_WINDOW, 64);
    write_register(REG_BUCKETS, 64);
    write_register(REG_LOW, 16'h8000);
    write_register(REG_HIGH, 16'h7FFF);
    write_register(REG_THRESH, 16'd20000);
    write_register(REG_HOLD, 3);
    queue_samples(60, GEN_ANY);
    wait_idle();

    repeat (4) random_phase(80);
    idling_on = 1'b0;
    random_phase(60);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS windowed_entropy_ratchet");
    end else begin
      $display("FAIL windowed_entropy_ratchet");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("FAIL windowed_entropy_ratchet");
    $finish;
  end

endmodule
